>>> hw/rtl/qsed_pkg.sv
// ----------------------------------------------------------------------------
// qsed_pkg
// Shared types and codes for the quoted string escape decoder: parse phases,
// result status codes, the parser state and the result beat layout.
// ----------------------------------------------------------------------------
package qsed_pkg;

   // Character codes the parser looks for
   localparam logic [7:0] CHAR_NUL       = 8'h00;
   localparam logic [7:0] CHAR_QUOTE     = 8'h22;
   localparam logic [7:0] CHAR_BACKSLASH = 8'h5c;
   localparam logic [7:0] CHAR_X         = 8'h78;
   localparam logic [7:0] CHAR_ZERO      = 8'h30;
   localparam logic [7:0] CHAR_THREE     = 8'h33;
   localparam logic [7:0] CHAR_SEVEN     = 8'h37;

   typedef enum logic [3:0] {
      PH_IDLE = 4'd0,
      PH_BODY = 4'd1,
      PH_ESC  = 4'd2,
      PH_HEX1 = 4'd3,
      PH_HEX2 = 4'd4,
      PH_OCT2 = 4'd5,
      PH_OCT3 = 4'd6
   } phase_type;

   typedef enum logic [3:0] {
      ST_BYTE      = 4'd0,
      ST_DONE      = 4'd1,
      ST_NO_OPEN   = 4'd2,
      ST_UNTERM    = 4'd3,
      ST_DANGLING  = 4'd4,
      ST_SHORT_HEX = 4'd5,
      ST_BAD_OCT   = 4'd6,
      ST_BAD_HEX   = 4'd7,
      ST_UNKNOWN   = 4'd8
   } status_type;

   typedef struct packed {
      phase_type  phase;
      logic [7:0] escape_value;
   } parse_state_type;

   typedef struct packed {
      logic [7:0] out_byte;
      status_type status;
      logic       is_last;
   } result_type;

endpackage

>>> hw/rtl/qsed_channel_if.sv
// ----------------------------------------------------------------------------
// qsed channel interfaces
// Valid/ready channels for raw literal bytes (request) and decoded results
// (response). A beat moves on a rising edge with valid and ready both high.
// ----------------------------------------------------------------------------
interface qsed_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_byte;
   logic       start_of_string;

   modport source (output valid, output char_byte, output start_of_string, input ready);
   modport sink   (input valid, input char_byte, input start_of_string, output ready);
endinterface

interface qsed_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic [3:0] status;
   logic       is_last;

   modport source (output valid, output out_byte, output status, output is_last, input ready);
   modport sink   (input valid, input out_byte, input status, input is_last, output ready);
endinterface

>>> hw/rtl/quoted_string_escape_decoder.sv
// ----------------------------------------------------------------------------
// quoted_string_escape_decoder
// Streaming decoder for a double-quoted string literal with C escapes.
//
//   channel  dir  payload                           handshake
//   req_bus  in   char_byte, start_of_string        valid / ready
//   rsp_bus  out  out_byte, status, is_last         valid / ready
//
// One byte is taken every cycle unless a stalled result holds the registers. A
// byte passes through the input register, then the parser step into the result
// register, where its result, if it has one, is offered.
// The parser state advances when the input register hands its byte on.
// A stalled result holds the result register, which in turn holds the input
// register; the input side stays ready while either register can move.
// Synchronous active-high reset returns the parser to waiting for a start.
// ----------------------------------------------------------------------------
module quoted_string_escape_decoder (
   input logic       clock,
   input logic       reset,
   qsed_req_if.sink  req_bus,
   qsed_rsp_if.source rsp_bus
);
   import qsed_pkg::*;

   logic            in_valid_ff;
   logic [7:0]      in_char_ff;
   logic            in_start_ff;
   parse_state_type state_ff;
   parse_state_type state_in;
   logic            rsp_valid_ff;
   result_type      rsp_data_ff;
   logic            step_valid;
   result_type      step_result;
   logic            out_free;
   logic            consume;

   assign out_free      = !rsp_valid_ff || rsp_bus.ready;
   assign consume       = in_valid_ff && out_free;
   assign req_bus.ready = !in_valid_ff || out_free;

   // Parser step on the registered byte
   qsed_decode u_decode (
      .state           (state_ff),
      .char_byte       (in_char_ff),
      .start_of_string (in_start_ff),
      .next_state      (state_in),
      .result_valid    (step_valid),
      .result          (step_result)
   );

   // Capture the incoming beat
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_bus.ready) begin
         in_valid_ff <= req_bus.valid;
      end
      if (req_bus.ready && req_bus.valid) begin
         in_char_ff  <= req_bus.char_byte;
         in_start_ff <= req_bus.start_of_string;
      end
   end

   // Advance the parser state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.phase        <= PH_IDLE;
         state_ff.escape_value <= 8'h00;
      end else if (consume) begin
         state_ff <= state_in;
      end
   end

   // Load or drain the result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= consume && step_valid;
      end
      if (consume && step_valid) begin
         rsp_data_ff <= step_result;
      end
   end

   assign rsp_bus.valid    = rsp_valid_ff;
   assign rsp_bus.out_byte = rsp_data_ff.out_byte;
   assign rsp_bus.status   = rsp_data_ff.status;
   assign rsp_bus.is_last  = rsp_data_ff.is_last;

   // A literal-ending result leaves the parser waiting for a start
   a_last_idles: assert property (@(posedge clock) disable iff (reset)
      (consume && step_valid && step_result.is_last) |=> (state_ff.phase == PH_IDLE))
      else $error("parser not idle after a literal-ending result");

   // A start byte that is not a quote reports a missing open quote
   a_no_open: assert property (@(posedge clock) disable iff (reset)
      (consume && in_start_ff && in_char_ff != CHAR_QUOTE)
      |=> (rsp_valid_ff && rsp_data_ff.status == ST_NO_OPEN && rsp_data_ff.is_last))
      else $error("missing open quote not reported");

   // Leading escape digits never produce a data byte
   a_digit_silent: assert property (@(posedge clock) disable iff (reset)
      (consume && !in_start_ff && (state_ff.phase == PH_HEX1 || state_ff.phase == PH_OCT2))
      |=> !(rsp_valid_ff && rsp_data_ff.status == ST_BYTE))
      else $error("data byte emitted mid-escape");

   // A consumed start-quote byte opens the literal body silently
   a_open_body: assert property (@(posedge clock) disable iff (reset)
      (consume && in_start_ff && in_char_ff == CHAR_QUOTE)
      |=> (state_ff.phase == PH_BODY && !rsp_valid_ff))
      else $error("open quote did not enter the body");

endmodule

>>> hw/rtl/qsed_decode.sv
// ----------------------------------------------------------------------------
// qsed_decode
// Single-pass parser step: from the current phase, the partial escape value
// and one raw byte, form the next parser state and at most one result.
// ----------------------------------------------------------------------------
module qsed_decode (
   input  qsed_pkg::parse_state_type state,
   input  logic [7:0]                char_byte,
   input  logic                      start_of_string,
   output qsed_pkg::parse_state_type next_state,
   output logic                      result_valid,
   output qsed_pkg::result_type      result
);
   import qsed_pkg::*;

   // Hex digit: bit 4 flags a valid digit, bits 3:0 carry its value
   function automatic logic [4:0] hex_digit(input logic [7:0] c);
      logic [7:0] d;
      d = 8'h00;
      if (c >= 8'h30 && c <= 8'h39) begin
         d = c - 8'h30;
         return {1'b1, d[3:0]};
      end
      if (c >= 8'h61 && c <= 8'h66) begin
         d = c - 8'h57;
         return {1'b1, d[3:0]};
      end
      if (c >= 8'h41 && c <= 8'h46) begin
         d = c - 8'h37;
         return {1'b1, d[3:0]};
      end
      return 5'd0;
   endfunction

   // Single-letter escape: bit 8 flags a known letter, bits 7:0 the byte
   function automatic logic [8:0] letter_escape(input logic [7:0] c);
      case (c)
         8'h61:   return {1'b1, 8'd7};
         8'h62:   return {1'b1, 8'd8};
         8'h65:   return {1'b1, 8'd27};
         8'h66:   return {1'b1, 8'd12};
         8'h6e:   return {1'b1, 8'd10};
         8'h72:   return {1'b1, 8'd13};
         8'h74:   return {1'b1, 8'd9};
         8'h76:   return {1'b1, 8'd11};
         8'h5c:   return {1'b1, 8'd92};
         8'h27:   return {1'b1, 8'd39};
         8'h22:   return {1'b1, 8'd34};
         8'h3f:   return {1'b1, 8'd63};
         default: return 9'd0;
      endcase
   endfunction

   logic [4:0] hex;
   logic [8:0] letter;
   logic       is_octal;
   status_type status;
   logic [7:0] data_byte;

   assign hex      = hex_digit(char_byte);
   assign letter   = letter_escape(char_byte);
   assign is_octal = (char_byte >= CHAR_ZERO) && (char_byte <= CHAR_SEVEN);

   // Advance the phase and pick the result
   always_comb begin
      next_state   = state;
      result_valid = 1'b0;
      status       = ST_BYTE;
      data_byte    = 8'h00;
      if (start_of_string) begin
         next_state.escape_value = 8'h00;
         if (char_byte != CHAR_QUOTE) begin
            result_valid = 1'b1;
            status       = ST_NO_OPEN;
         end else begin
            next_state.phase = PH_BODY;
         end
      end else begin
         case (state.phase)
            PH_BODY: begin
               if (char_byte == CHAR_NUL) begin
                  result_valid = 1'b1;
                  status       = ST_UNTERM;
               end else if (char_byte == CHAR_QUOTE) begin
                  result_valid = 1'b1;
                  status       = ST_DONE;
               end else if (char_byte == CHAR_BACKSLASH) begin
                  next_state.phase = PH_ESC;
               end else begin
                  result_valid = 1'b1;
                  data_byte    = char_byte;
               end
            end
            PH_ESC: begin
               if (char_byte == CHAR_NUL) begin
                  result_valid = 1'b1;
                  status       = ST_DANGLING;
               end else if (char_byte == CHAR_X) begin
                  next_state.escape_value = 8'h00;
                  next_state.phase        = PH_HEX1;
               end else if (char_byte >= CHAR_ZERO && char_byte <= CHAR_THREE) begin
                  next_state.escape_value = {char_byte[1:0], 6'b0};
                  next_state.phase        = PH_OCT2;
               end else if (!letter[8]) begin
                  result_valid = 1'b1;
                  status       = ST_UNKNOWN;
               end else begin
                  result_valid     = 1'b1;
                  data_byte        = letter[7:0];
                  next_state.phase = PH_BODY;
               end
            end
            PH_HEX1, PH_HEX2: begin
               if (char_byte == CHAR_NUL) begin
                  result_valid = 1'b1;
                  status       = ST_SHORT_HEX;
               end else if (!hex[4]) begin
                  result_valid = 1'b1;
                  status       = ST_BAD_HEX;
               end else if (state.phase == PH_HEX1) begin
                  next_state.escape_value = {hex[3:0], 4'b0};
                  next_state.phase        = PH_HEX2;
               end else begin
                  result_valid     = 1'b1;
                  data_byte        = state.escape_value | {4'b0, hex[3:0]};
                  next_state.phase = PH_BODY;
               end
            end
            PH_OCT2, PH_OCT3: begin
               if (!is_octal) begin
                  result_valid = 1'b1;
                  status       = ST_BAD_OCT;
               end else if (state.phase == PH_OCT2) begin
                  next_state.escape_value = state.escape_value + {2'b0, char_byte[2:0], 3'b0};
                  next_state.phase        = PH_OCT3;
               end else begin
                  result_valid     = 1'b1;
                  data_byte        = state.escape_value + {5'b0, char_byte[2:0]};
                  next_state.phase = PH_BODY;
               end
            end
            default: begin
               next_state.phase = PH_IDLE;
            end
         endcase
      end
      // Any status other than a byte ends the literal
      if (result_valid && status != ST_BYTE) begin
         next_state.phase = PH_IDLE;
      end
   end

   // Pack the result beat
   always_comb begin
      result.status   = status;
      result.is_last  = (status != ST_BYTE);
      result.out_byte = (status == ST_BYTE) ? data_byte : 8'h00;
   end

endmodule

>>> sim/tb_quoted_string_escape_decoder.sv
// ----------------------------------------------------------------------------
// tb_quoted_string_escape_decoder
// Self-checking bench for the quoted string escape decoder. A short table of
// literal bytes exercises each status code, restarts and ignored bytes. Random
// literals follow, built from plain bytes and letter, octal and hex escapes,
// some of them corrupted. A predictor in the bench tracks the parse phase and
// expects each result beat. Both channels idle at random, and the response
// side also stalls for a long stretch.
// ----------------------------------------------------------------------------
module tb_quoted_string_escape_decoder;
   import qsed_pkg::*;

   // One directed beat. A pinned row carries its result typed in by hand.
   typedef struct packed {
      logic [7:0] ch;
      logic       start;
      logic       pinned;
      logic       pin_fire;
      result_type pin_res;
   } probe_row_type;

   logic clock;
   logic reset;

   qsed_req_if req_bus ();
   qsed_rsp_if rsp_bus ();

   quoted_string_escape_decoder i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   // Predictor state and expected result beats
   phase_type  dec_phase;
   logic [7:0] dec_value;
   result_type decoded_q[$];
   int         mismatch_count = 0;

   // Pinned result of the beat on offer, read when that beat is accepted
   logic       pin_on   = 1'b0;
   logic       pin_fire = 1'b0;
   result_type pin_res  = '0;

   // Request-side idle control, a response hold that it sets, and its byte count
   bit         sender_steady = 1'b0;
   bit         hold_out      = 1'b0;
   int         lit_items     = 0;

   logic [7:0] escape_letters [12] = '{"a", "b", "e", "f", "n", "r", "t", "v",
                                       "\\", "'", "\"", "?"};

   probe_row_type probe_tab[$];

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      reset = 1'b1;
      repeat (3) @(negedge clock);
      reset <= 1'b0;
   end

   initial begin
      #5_000_000;
      $display("FAIL quoted_string_escape_decoder");
      $finish;
   end

   // Advance the parser by one raw byte; fire is set when a result is due
   function automatic void decode_step(input logic [7:0] c, input logic s,
                                       output bit fire, output result_type res);
      status_type st;
      logic [7:0] b;
      logic [4:0] d;
      fire = 1'b0;
      st   = ST_BYTE;
      b    = 8'h00;
      d    = 5'd16;
      if (c >= "0" && c <= "9") d = 5'(c - "0");
      else if (c >= "a" && c <= "f") d = 5'(c - "a" + 8'd10);
      else if (c >= "A" && c <= "F") d = 5'(c - "A" + 8'd10);

      if (s) begin
         dec_value = 8'h00;
         if (c != CHAR_QUOTE) begin
            fire = 1'b1;
            st   = ST_NO_OPEN;
         end else begin
            dec_phase = PH_BODY;
         end
      end else begin
         case (dec_phase)
            PH_BODY: begin
               if (c == CHAR_NUL) begin
                  fire = 1'b1;
                  st   = ST_UNTERM;
               end else if (c == CHAR_QUOTE) begin
                  fire = 1'b1;
                  st   = ST_DONE;
               end else if (c == CHAR_BACKSLASH) begin
                  dec_phase = PH_ESC;
               end else begin
                  fire = 1'b1;
                  b    = c;
               end
            end
            PH_ESC: begin
               if (c == CHAR_NUL) begin
                  fire = 1'b1;
                  st   = ST_DANGLING;
               end else if (c == CHAR_X) begin
                  dec_value = 8'h00;
                  dec_phase = PH_HEX1;
               end else if (c >= CHAR_ZERO && c <= CHAR_THREE) begin
                  dec_value = {c[1:0], 6'b000000};
                  dec_phase = PH_OCT2;
               end else begin
                  fire      = 1'b1;
                  dec_phase = PH_BODY;
                  case (c)
                     "a":     b = 8'd7;
                     "b":     b = 8'd8;
                     "e":     b = 8'd27;
                     "f":     b = 8'd12;
                     "n":     b = 8'd10;
                     "r":     b = 8'd13;
                     "t":     b = 8'd9;
                     "v":     b = 8'd11;
                     "\\":    b = 8'd92;
                     "'":     b = 8'd39;
                     "\"":    b = 8'd34;
                     "?":     b = 8'd63;
                     default: st = ST_UNKNOWN;
                  endcase
               end
            end
            PH_HEX1, PH_HEX2: begin
               if (c == CHAR_NUL) begin
                  fire = 1'b1;
                  st   = ST_SHORT_HEX;
               end else if (d == 5'd16) begin
                  fire = 1'b1;
                  st   = ST_BAD_HEX;
               end else if (dec_phase == PH_HEX1) begin
                  dec_value = {d[3:0], 4'h0};
                  dec_phase = PH_HEX2;
               end else begin
                  fire      = 1'b1;
                  b         = dec_value | {4'h0, d[3:0]};
                  dec_phase = PH_BODY;
               end
            end
            PH_OCT2, PH_OCT3: begin
               if (c < CHAR_ZERO || c > CHAR_SEVEN) begin
                  fire = 1'b1;
                  st   = ST_BAD_OCT;
               end else if (dec_phase == PH_OCT2) begin
                  dec_value = dec_value + {2'b00, c[2:0], 3'b000};
                  dec_phase = PH_OCT3;
               end else begin
                  fire      = 1'b1;
                  b         = dec_value + {5'b00000, c[2:0]};
                  dec_phase = PH_BODY;
               end
            end
            default: dec_phase = PH_IDLE;
         endcase
      end

      res.out_byte = (st == ST_BYTE) ? b : 8'h00;
      res.status   = st;
      res.is_last  = (st != ST_BYTE);
      if (fire && st != ST_BYTE) dec_phase = PH_IDLE;
   endfunction

   function automatic probe_row_type pinned(logic [7:0] ch, logic start, logic fire,
                                            status_type st, logic [7:0] b);
      probe_row_type p;
      p.ch               = ch;
      p.start            = start;
      p.pinned           = 1'b1;
      p.pin_fire         = fire;
      p.pin_res.out_byte = (st == ST_BYTE) ? b : 8'h00;
      p.pin_res.status   = st;
      p.pin_res.is_last  = (st != ST_BYTE);
      return p;
   endfunction

   function automatic probe_row_type free_row(logic [7:0] ch, logic start);
      probe_row_type p;
      p        = '0;
      p.ch     = ch;
      p.start  = start;
      return p;
   endfunction

   // Mostly back to back, some short gaps, a few long ones
   function automatic int pick_gap(bit steady);
      int r;
      r = $urandom_range(0, 99);
      if (steady || r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // Offer one beat and hold it until accepted; returns at the accepting edge
   task automatic offer(input probe_row_type p);
      int gap;
      gap = pick_gap(sender_steady);
      @(negedge clock);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      pin_on   = p.pinned;
      pin_fire = p.pin_fire;
      pin_res  = p.pin_res;
      req_bus.valid           <= 1'b1;
      req_bus.char_byte       <= p.ch;
      req_bus.start_of_string <= p.start;
      do @(posedge clock); while (!(req_bus.valid && req_bus.ready));
      lit_items++;
   endtask

   // Drop valid and hold until every expected result has come back
   task automatic drain_pause();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (decoded_q.size() != 0) @(negedge clock);
   endtask

   // One literal byte, sometimes swapped for noise when the literal is spoiled
   task automatic put(input logic [7:0] b, input logic s, input bit spoil);
      if (spoil && $urandom_range(0, 5) == 0) begin
         b = ($urandom_range(0, 3) == 0) ? CHAR_NUL : 8'($urandom_range(0, 255));
         s = ($urandom_range(0, 9) == 0);
      end
      offer(free_row(b, s));
   endtask

   task automatic send_literal(input int body_len, input bit spoil);
      logic [7:0] b;
      int         v;
      put(CHAR_QUOTE, 1'b1, spoil);
      repeat (body_len) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: begin
               do b = 8'($urandom_range(1, 255));
               while (b == CHAR_QUOTE || b == CHAR_BACKSLASH);
               put(b, 1'b0, spoil);
            end
            5, 6: begin
               put(CHAR_BACKSLASH, 1'b0, spoil);
               put(escape_letters[$urandom_range(0, 11)], 1'b0, spoil);
            end
            7: begin
               put(CHAR_BACKSLASH, 1'b0, spoil);
               put(8'(CHAR_ZERO + $urandom_range(0, 3)), 1'b0, spoil);
               put(8'(CHAR_ZERO + $urandom_range(0, 7)), 1'b0, spoil);
               put(8'(CHAR_ZERO + $urandom_range(0, 7)), 1'b0, spoil);
            end
            default: begin
               put(CHAR_BACKSLASH, 1'b0, spoil);
               put(CHAR_X, 1'b0, spoil);
               repeat (2) begin
                  v = $urandom_range(0, 15);
                  if (v < 10) b = 8'(CHAR_ZERO + v);
                  else b = 8'((($urandom_range(0, 1) != 0) ? "a" : "A") + v - 10);
                  put(b, 1'b0, spoil);
               end
            end
         endcase
      end
      put(($urandom_range(0, 15) == 0) ? CHAR_NUL : CHAR_QUOTE, 1'b0, spoil);
   endtask

   // Request side: directed table, then random literals
   initial begin
      int lit_index;
      req_bus.valid           = 1'b0;
      req_bus.char_byte       = 8'h00;
      req_bus.start_of_string = 1'b0;
      probe_tab = '{
         // ignored while waiting, a start that is not a quote, then an open and a byte
         pinned(8'hFF, 1'b0, 1'b0, ST_BYTE, 8'h00),
         pinned(CHAR_NUL, 1'b1, 1'b1, ST_NO_OPEN, 8'h00),
         pinned(CHAR_QUOTE, 1'b1, 1'b0, ST_BYTE, 8'h00),
         pinned(8'hFF, 1'b0, 1'b1, ST_BYTE, 8'hFF),
         // largest octal escape
         free_row(CHAR_BACKSLASH, 1'b0),
         free_row(CHAR_THREE, 1'b0),
         free_row(CHAR_SEVEN, 1'b0),
         pinned(CHAR_SEVEN, 1'b0, 1'b1, ST_BYTE, 8'hFF),
         // restart in the middle of a hex escape, then close
         free_row(CHAR_BACKSLASH, 1'b0),
         free_row(CHAR_X, 1'b0),
         pinned(CHAR_QUOTE, 1'b1, 1'b0, ST_BYTE, 8'h00),
         pinned(CHAR_QUOTE, 1'b0, 1'b1, ST_DONE, 8'h00),
         pinned("Q", 1'b0, 1'b0, ST_BYTE, 8'h00),
         // end of text in the body
         free_row(CHAR_QUOTE, 1'b1),
         pinned(CHAR_NUL, 1'b0, 1'b1, ST_UNTERM, 8'h00),
         // end of text right after a backslash
         free_row(CHAR_QUOTE, 1'b1),
         free_row(CHAR_BACKSLASH, 1'b0),
         pinned(CHAR_NUL, 1'b0, 1'b1, ST_DANGLING, 8'h00),
         // end of text inside hex digits
         free_row(CHAR_QUOTE, 1'b1),
         free_row(CHAR_BACKSLASH, 1'b0),
         free_row(CHAR_X, 1'b0),
         free_row("a", 1'b0),
         pinned(CHAR_NUL, 1'b0, 1'b1, ST_SHORT_HEX, 8'h00),
         // unlisted escape letter
         free_row(CHAR_QUOTE, 1'b1),
         free_row(CHAR_BACKSLASH, 1'b0),
         pinned("q", 1'b0, 1'b1, ST_UNKNOWN, 8'h00),
         // non-octal second digit
         free_row(CHAR_QUOTE, 1'b1),
         free_row(CHAR_BACKSLASH, 1'b0),
         free_row("1", 1'b0),
         pinned("8", 1'b0, 1'b1, ST_BAD_OCT, 8'h00),
         // non-hex digit
         free_row(CHAR_QUOTE, 1'b1),
         free_row(CHAR_BACKSLASH, 1'b0),
         free_row(CHAR_X, 1'b0),
         pinned("G", 1'b0, 1'b1, ST_BAD_HEX, 8'h00)
      };
      @(negedge clock);
      while (reset) @(negedge clock);

      foreach (probe_tab[i]) offer(probe_tab[i]);
      drain_pause();

      lit_index = 0;
      while (lit_items < 650) begin
         if (lit_index == 4) begin
            // stall the response side while beats keep coming
            hold_out      = 1'b1;
            sender_steady = 1'b1;
            send_literal(24, 1'b0);
         end else begin
            if (lit_index == 12) drain_pause();
            sender_steady = ($urandom_range(0, 3) == 0);
            send_literal(($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                     : $urandom_range(0, 8),
                         ($urandom_range(0, 3) == 0));
         end
         // stray bytes between literals
         if ($urandom_range(0, 2) == 0) begin
            repeat ($urandom_range(1, 3))
               offer(free_row(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0));
         end
         lit_index++;
      end

      drain_pause();
      repeat (8) @(negedge clock);
      if (mismatch_count == 0) $display("PASS quoted_string_escape_decoder");
      else $display("FAIL quoted_string_escape_decoder");
      $finish;
   end

   // Response side: random stalls, steady stretches and one long hold
   initial begin
      int stall;
      int drain_beats;
      bit drain_steady;
      drain_beats   = 0;
      drain_steady  = 1'b0;
      rsp_bus.ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_out) begin
            hold_out = 1'b0;
            rsp_bus.ready <= 1'b0;
            repeat (80) @(negedge clock);
         end else begin
            if (drain_beats % 64 == 0) drain_steady = ($urandom_range(0, 3) == 0);
            drain_beats++;
            stall = pick_gap(drain_steady);
            if (stall > 0) begin
               rsp_bus.ready <= 1'b0;
               repeat (stall) @(negedge clock);
            end
            rsp_bus.ready <= 1'b1;
            @(negedge clock);
         end
      end
   end

   // Predict on each accepted byte, check each accepted result
   always @(posedge clock) begin
      bit         fire;
      result_type want;
      if (reset) begin
         dec_phase = PH_IDLE;
         dec_value = 8'h00;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            decode_step(req_bus.char_byte, req_bus.start_of_string, fire, want);
            if (pin_on) begin
               fire = pin_fire;
               want = pin_res;
            end
            if (fire) decoded_q.push_back(want);
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (decoded_q.size() == 0) begin
               $display("%0t: result beat with nothing pending: byte %02h status %0d last %0b",
                        $time, rsp_bus.out_byte, rsp_bus.status, rsp_bus.is_last);
               mismatch_count++;
            end else begin
               want = decoded_q.pop_front();
               if (want.out_byte !== rsp_bus.out_byte) begin
                  $display("%0t: out_byte expected %02h, actual %02h",
                           $time, want.out_byte, rsp_bus.out_byte);
                  mismatch_count++;
               end
               if (want.status !== rsp_bus.status) begin
                  $display("%0t: status expected %0d, actual %0d",
                           $time, want.status, rsp_bus.status);
                  mismatch_count++;
               end
               if (want.is_last !== rsp_bus.is_last) begin
                  $display("%0t: is_last expected %0b, actual %0b",
                           $time, want.is_last, rsp_bus.is_last);
                  mismatch_count++;
               end
            end
         end
      end
   end

endmodule
